// File: sv/ssl_pkg.sv
// Shared constants and sideband types for the selectable slope limiter.
`default_nettype none

package ssl_pkg;

	localparam int FRAC_BITS = 32;   // fraction bits of the fixed point format
	localparam int QUOT_BITS = 49;   // quotient bits of the final divider
	localparam int NUM_W     = 96;   // dividend width of the final divider
	localparam int DEN_W     = 49;   // divisor width of the final divider
	localparam int RAT_W     = 97;   // operand width of the unit fraction divider

	localparam logic [2:0] MODE_LINEAR    = 3'd0;
	localparam logic [2:0] MODE_SMOOTH    = 3'd1;
	localparam logic [2:0] MODE_VANLEER   = 3'd2;
	localparam logic [2:0] MODE_MODSMOOTH = 3'd3;
	localparam logic [2:0] MODE_MINMOD    = 3'd4;

	localparam logic       REG_MODE = 1'b0;
	localparam logic       REG_EPS  = 1'b1;

	localparam logic [2:0]  MODE_RESET = MODE_MINMOD;
	localparam logic [31:0] EPS_RESET  = 32'd4295;

	// travels alongside the unit fraction divider
	typedef struct packed {
		logic               fz;        // fraction forced to zero
		logic               fo;        // fraction forced to one
		logic               nneg;      // fraction is negative
		logic signed [48:0] sum;       // a + b
		logic [47:0]        dmag;      // |a - b|
		logic               difneg;    // a - b < 0
		logic [95:0]        dnum;      // dividend for linear and van Leer
		logic [48:0]        ddiv;      // divisor for linear and van Leer
		logic               dneg;      // quotient sign for linear and van Leer
		logic               zero_res;  // result is zero
		logic               use_direct;
		logic [47:0]        direct;    // minmod result
		logic               half;      // mod-smooth with one zero input
	} fside_t;

	// travels alongside the final divider
	typedef struct packed {
		logic        dneg;
		logic        zero_res;
		logic        use_direct;
		logic [47:0] direct;
	} lside_t;

endpackage

`default_nettype wire

// File: sv/ssl_in_if.sv
// Input channel: one pair of neighboring differences per beat.
`default_nettype none

interface ssl_in_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] left_difference;
	logic signed [47:0] right_difference;

	modport source(output valid, output left_difference, output right_difference,
		input ready);
	modport sink(input valid, input left_difference, input right_difference,
		output ready);
endinterface

`default_nettype wire

// File: sv/ssl_out_if.sv
// Output channel: one limited slope per beat.
`default_nettype none

interface ssl_out_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] limited_value;
	logic               invalid_mode;

	modport source(output valid, output limited_value, output invalid_mode, input ready);
	modport sink(input valid, input limited_value, input invalid_mode, output ready);
endinterface

`default_nettype wire

// File: sv/selectable_slope_limiter_unit.sv
// Top level of the selectable slope limiter: front end, multiply stages, dividers, output.
// Usage:
//   diff_in carries one beat per pair (left_difference, right_difference), both
//   signed Q16.32. slope_out returns one beat per input beat, in order, with the
//   limited slope (saturated to 48 bits) and invalid_mode, set for modes 5 to 7
//   with a zero slope. wr_en/wr_index/wr_data write limiter_mode (index 0) and
//   epsilon (index 1); write them only while no beat is in flight.
// Timing:
//   Fully pipelined, one beat per cycle while slope_out.ready stays high. A beat passes
//   93 registers, the first loaded at the accepting edge: 4 front stages (magnitudes,
//   24x24 partial products, squares, numerator/denominator), 33 stages of the unit
//   fraction divider, 5 multiply stages, 50 stages of the final divider and the
//   output register. The two bit-serial dividers set the depth.
// Reset and stall:
//   arst_n clears all valid bits and loads limiter_mode 4 (minmod) and
//   epsilon 4295. The whole pipeline advances together; while a result waits in
//   the output register and the receiver holds ready low, diff_in.ready is low
//   and every stage holds. Bubbles travel as invalid stages.
`default_nettype none

module selectable_slope_limiter_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ssl_in_if.sink           diff_in,
	ssl_out_if.source        slope_out,
	input  wire logic        wr_en,
	input  wire logic        wr_index,
	input  wire logic [31:0] wr_data
);
	localparam int F = ssl_pkg::FRAC_BITS;

	// configuration
	logic [2:0]  mode_q;
	logic [31:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ssl_pkg::MODE_RESET;
			eps_q  <= ssl_pkg::EPS_RESET;
		end else if (wr_en) begin
			case (wr_index)
				ssl_pkg::REG_MODE: mode_q <= wr_data[2:0];
				ssl_pkg::REG_EPS:  eps_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// global advance: move when the output register is empty or being drained
	logic adv;
	logic ovalid_q;
	assign adv           = !ovalid_q || slope_out.ready;
	assign diff_in.ready = adv;

	// ---------------- S1: operands, magnitudes, sum and difference
	logic               v_s1;
	logic signed [47:0] a_s1, b_s1;
	logic [47:0]        ma_s1, mb_s1;
	logic signed [48:0] sum_s1, dif_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1   <= diff_in.left_difference;
			b_s1   <= diff_in.right_difference;
			ma_s1  <= diff_in.left_difference[47] ? 48'(-diff_in.left_difference)
				: 48'(diff_in.left_difference);
			mb_s1  <= diff_in.right_difference[47] ? 48'(-diff_in.right_difference)
				: 48'(diff_in.right_difference);
			sum_s1 <= 49'(diff_in.left_difference) + 49'(diff_in.right_difference);
			dif_s1 <= 49'(diff_in.left_difference) - 49'(diff_in.right_difference);
		end
	end

	// ---------------- S2: 24x24 partial products
	logic               v_s2;
	logic signed [47:0] a_s2, b_s2;
	logic [47:0]        ma_s2, mb_s2;
	logic signed [48:0] sum_s2;
	logic [47:0]        dmag_s2;
	logic               difneg_s2;
	logic [47:0]        aa_hh_s2, aa_hl_s2, aa_ll_s2;
	logic [47:0]        bb_hh_s2, bb_hl_s2, bb_ll_s2;
	logic [47:0]        ab_hh_s2, ab_hl_s2, ab_lh_s2, ab_ll_s2;
	logic [63:0]        eps2_s2;
	logic [48:0]        dabs_c;

	assign dabs_c = dif_s1[48] ? 49'(-dif_s1) : 49'(dif_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2      <= a_s1;
			b_s2      <= b_s1;
			ma_s2     <= ma_s1;
			mb_s2     <= mb_s1;
			sum_s2    <= sum_s1;
			dmag_s2   <= dabs_c[47:0];
			difneg_s2 <= dif_s1[48];
			aa_hh_s2  <= 48'(ma_s1[47:24]) * 48'(ma_s1[47:24]);
			aa_hl_s2  <= 48'(ma_s1[47:24]) * 48'(ma_s1[23:0]);
			aa_ll_s2  <= 48'(ma_s1[23:0]) * 48'(ma_s1[23:0]);
			bb_hh_s2  <= 48'(mb_s1[47:24]) * 48'(mb_s1[47:24]);
			bb_hl_s2  <= 48'(mb_s1[47:24]) * 48'(mb_s1[23:0]);
			bb_ll_s2  <= 48'(mb_s1[23:0]) * 48'(mb_s1[23:0]);
			ab_hh_s2  <= 48'(ma_s1[47:24]) * 48'(mb_s1[47:24]);
			ab_hl_s2  <= 48'(ma_s1[47:24]) * 48'(mb_s1[23:0]);
			ab_lh_s2  <= 48'(ma_s1[23:0]) * 48'(mb_s1[47:24]);
			ab_ll_s2  <= 48'(ma_s1[23:0]) * 48'(mb_s1[23:0]);
			eps2_s2   <= 64'(eps_q) * 64'(eps_q);
		end
	end

	// ---------------- S3: a^2, b^2, a*b
	logic               v_s3;
	logic signed [47:0] a_s3, b_s3;
	logic [47:0]        ma_s3, mb_s3;
	logic signed [48:0] sum_s3;
	logic [47:0]        dmag_s3;
	logic               difneg_s3;
	logic [95:0]        sqa_s3, sqb_s3, pab_s3;
	logic [63:0]        eps2_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s3      <= a_s2;
			b_s3      <= b_s2;
			ma_s3     <= ma_s2;
			mb_s3     <= mb_s2;
			sum_s3    <= sum_s2;
			dmag_s3   <= dmag_s2;
			difneg_s3 <= difneg_s2;
			eps2_s3   <= eps2_s2;
			sqa_s3    <= (96'(aa_hh_s2) << 48) + (96'(aa_hl_s2) << 25) + 96'(aa_ll_s2);
			sqb_s3    <= (96'(bb_hh_s2) << 48) + (96'(bb_hl_s2) << 25) + 96'(bb_ll_s2);
			pab_s3    <= (96'(ab_hh_s2) << 48) + ((96'(ab_hl_s2) + 96'(ab_lh_s2)) << 24)
				+ 96'(ab_ll_s2);
		end
	end

	// ---------------- S4: guard, numerator, denominator, per-mode setup
	logic               v_s4;
	logic [96:0]        num_s4, den_s4;
	ssl_pkg::fside_t    fs_s4;

	logic [63:0]        guard_c;
	logic [96:0]        cross_c, num_c, den_c;
	logic               nneg_c, same_c, a_nz_c, b_nz_c, rpos_c;
	logic signed [49:0] lin_c;
	logic [49:0]        linmag_c;
	logic [48:0]        summag_c;
	ssl_pkg::fside_t    fs_c;

	always_comb begin
		guard_c  = (mode_q == ssl_pkg::MODE_SMOOTH) ? {eps_q, {F{1'b0}}} : eps2_s3;
		den_c    = 97'(sqa_s3) + 97'(sqb_s3) + 97'(guard_c);
		cross_c  = {pab_s3, 1'b0};
		same_c   = a_s3[47] == b_s3[47];
		nneg_c   = 1'b0;
		if (same_c) begin
			num_c = cross_c + 97'(guard_c);
		end else if (cross_c > 97'(guard_c)) begin
			num_c  = cross_c - 97'(guard_c);
			nneg_c = 1'b1;
		end else begin
			num_c = 97'(guard_c) - cross_c;
		end
		a_nz_c   = |a_s3;
		b_nz_c   = |b_s3;
		// ratio counts only above the squared guard and for equal nonzero signs
		rpos_c   = ({mb_s3, {F{1'b0}}} > 80'(eps2_s3)) && a_nz_c && b_nz_c && same_c;
		lin_c    = (50'(a_s3) <<< 1) + 50'(b_s3);
		linmag_c = lin_c[49] ? 50'(-lin_c) : 50'(lin_c);
		summag_c = sum_s3[48] ? 49'(-sum_s3) : 49'(sum_s3);

		fs_c            = '0;
		fs_c.nneg       = nneg_c;
		fs_c.sum        = sum_s3;
		fs_c.dmag       = dmag_s3;
		fs_c.difneg     = difneg_s3;
		fs_c.ddiv       = 49'd1;
		case (mode_q)
			ssl_pkg::MODE_LINEAR: begin
				fs_c.dnum = 96'(linmag_c);
				fs_c.ddiv = 49'd3;
				fs_c.dneg = lin_c[49];
			end
			ssl_pkg::MODE_SMOOTH: ;
			ssl_pkg::MODE_VANLEER: begin
				fs_c.dnum     = {pab_s3[94:0], 1'b0};
				fs_c.ddiv     = summag_c;
				fs_c.dneg     = a_s3[47];
				fs_c.zero_res = !rpos_c;
			end
			ssl_pkg::MODE_MODSMOOTH: begin
				// |sgn a + sgn b|: two for equal nonzero signs, one for a single zero
				fs_c.zero_res = !((a_nz_c && b_nz_c && same_c) || (a_nz_c != b_nz_c));
				fs_c.half     = a_nz_c != b_nz_c;
			end
			ssl_pkg::MODE_MINMOD: begin
				fs_c.use_direct = 1'b1;
				fs_c.direct     = !rpos_c ? 48'd0 : (ma_s3 < mb_s3) ? a_s3 : b_s3;
			end
			default: fs_c.zero_res = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s4 <= num_c;
			den_s4 <= den_c;
			fs_s4  <= fs_c;
		end
	end

	// forced fraction cases: zero denominator, and ratio at or above one
	ssl_pkg::fside_t fin_c;
	always_comb begin
		fin_c    = fs_s4;
		fin_c.fz = den_s4 == '0;
		fin_c.fo = (den_s4 != '0) && (num_s4 >= den_s4);
	end

	// ---------------- unit fraction divider
	logic                fv;
	logic [F-1:0]        fq;
	ssl_pkg::fside_t     fs_f;

	ssl_frac_div u_frac (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s4),
		.in_num    (num_s4),
		.in_den    (den_s4),
		.in_side   (fin_c),
		.out_valid (fv),
		.out_q     (fq),
		.out_side  (fs_f)
	);

	// ---------------- P1: s * |a - b| partial products, 3(a + b)
	logic               v_p1;
	logic [32:0]        smag_p1;
	logic [56:0]        ph_p1, pl_p1;
	logic signed [50:0] t3_p1;
	ssl_pkg::fside_t    fs_p1;
	logic [32:0]        smag_c;

	assign smag_c = fs_f.fz ? 33'd0 : fs_f.fo ? (33'd1 << F) : 33'(fq);

	always_ff @(posedge clk) begin
		if (adv) begin
			smag_p1 <= smag_c;
			ph_p1   <= 57'(smag_c) * 57'(fs_f.dmag[47:24]);
			pl_p1   <= 57'(smag_c) * 57'(fs_f.dmag[23:0]);
			t3_p1   <= (51'(fs_f.sum) <<< 1) + 51'(fs_f.sum);
			fs_p1   <= fs_f;
		end
	end

	// ---------------- P2: |s (a - b)|
	logic               v_p2;
	logic [32:0]        smag_p2;
	logic [80:0]        prod_p2;
	logic signed [50:0] t3_p2;
	ssl_pkg::fside_t    fs_p2;

	always_ff @(posedge clk) begin
		if (adv) begin
			smag_p2 <= smag_p1;
			prod_p2 <= (81'(ph_p1) << 24) + 81'(pl_p1);
			t3_p2   <= t3_p1;
			fs_p2   <= fs_p1;
		end
	end

	// ---------------- P3: inner = 3(a + b) 2^F + s (a - b)
	logic               v_p3;
	logic [32:0]        smag_p3;
	logic signed [83:0] inner_p3;
	ssl_pkg::fside_t    fs_p3;
	logic signed [83:0] tsh_c, prs_c;

	assign tsh_c = 84'(t3_p2) <<< F;
	assign prs_c = $signed(84'(prod_p2));

	always_ff @(posedge clk) begin
		if (adv) begin
			smag_p3  <= smag_p2;
			inner_p3 <= (fs_p2.nneg ^ fs_p2.difneg) ? tsh_c - prs_c : tsh_c + prs_c;
			fs_p3    <= fs_p2;
		end
	end

	// ---------------- P4: J = inner / 2^F toward zero
	logic               v_p4;
	logic [32:0]        smag_p4;
	logic [51:0]        jmag_p4;
	logic               jneg_p4;
	ssl_pkg::fside_t    fs_p4;
	logic [83:0]        iabs_c;

	assign iabs_c = inner_p3[83] ? 84'(-inner_p3) : 84'(inner_p3);

	always_ff @(posedge clk) begin
		if (adv) begin
			smag_p4 <= smag_p3;
			jmag_p4 <= iabs_c[83:F];
			jneg_p4 <= inner_p3[83];
			fs_p4   <= fs_p3;
		end
	end

	// ---------------- P5: J * s partial products
	logic               v_p5;
	logic [58:0]        pa_p5, pb_p5;
	logic               pneg_p5;
	ssl_pkg::fside_t    fs_p5;

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_p5   <= 59'(jmag_p4[51:26]) * 59'(smag_p4);
			pb_p5   <= 59'(jmag_p4[25:0]) * 59'(smag_p4);
			pneg_p5 <= jneg_p4 ^ fs_p4.nneg;
			fs_p5   <= fs_p4;
		end
	end

	// ---------------- P6 (comb): dividend and divisor for the final divider
	logic [84:0]         pm_c;
	logic [52:0]         pp_c, lim_c, pc_c;
	logic [48:0]         k_c;
	logic [95:0]         lnum_c;
	logic [48:0]         lden_c;
	ssl_pkg::lside_t     lin_side_c;
	logic                smooth_c;

	always_comb begin
		pm_c     = (85'(pa_p5) << 26) + 85'(pb_p5);
		pp_c     = pm_c[84:F];
		k_c      = (mode_q == ssl_pkg::MODE_MODSMOOTH && fs_p5.half) ? 49'd12 : 49'd6;
		// clamp keeps the quotient within the divider; the value saturates anyway
		lim_c    = 53'(k_c) << 48;
		pc_c     = (pp_c > lim_c) ? lim_c : pp_c;
		smooth_c = (mode_q == ssl_pkg::MODE_SMOOTH) || (mode_q == ssl_pkg::MODE_MODSMOOTH);

		lin_side_c.zero_res   = fs_p5.zero_res;
		lin_side_c.use_direct = fs_p5.use_direct;
		lin_side_c.direct     = fs_p5.direct;
		if (smooth_c) begin
			lnum_c          = 96'(pc_c);
			lden_c          = k_c;
			lin_side_c.dneg = pneg_p5;
		end else begin
			lnum_c          = fs_p5.dnum;
			lden_c          = fs_p5.ddiv;
			lin_side_c.dneg = fs_p5.dneg;
		end
	end

	// ---------------- final divider
	logic                            lv;
	logic [ssl_pkg::QUOT_BITS-1:0]   lq;
	ssl_pkg::lside_t                 ls_l;

	ssl_long_div u_long (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_p5),
		.in_num    (lnum_c),
		.in_den    (lden_c),
		.in_side   (lin_side_c),
		.out_valid (lv),
		.out_q     (lq),
		.out_side  (ls_l)
	);

	// ---------------- sign, saturation and output register
	logic [47:0] res_c;
	logic [47:0] val_q;
	logic        inv_q;

	always_comb begin
		if (ls_l.zero_res) begin
			res_c = '0;
		end else if (ls_l.use_direct) begin
			res_c = ls_l.direct;
		end else if (ls_l.dneg) begin
			res_c = (lq >= 49'h0_8000_0000_0000) ? 48'h8000_0000_0000
				: 48'(48'd0 - lq[47:0]);
		end else begin
			res_c = (lq > 49'h0_7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : lq[47:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_q <= res_c;
			inv_q <= mode_q > ssl_pkg::MODE_MINMOD;
		end
	end

	// valid bits of the top-level stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_p1     <= 1'b0;
			v_p2     <= 1'b0;
			v_p3     <= 1'b0;
			v_p4     <= 1'b0;
			v_p5     <= 1'b0;
			ovalid_q <= 1'b0;
		end else if (adv) begin
			v_s1     <= diff_in.valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			v_p1     <= fv;
			v_p2     <= v_p1;
			v_p3     <= v_p2;
			v_p4     <= v_p3;
			v_p5     <= v_p4;
			ovalid_q <= lv;
		end
	end

	assign slope_out.valid         = ovalid_q;
	assign slope_out.limited_value = $signed(val_q);
	assign slope_out.invalid_mode  = inv_q;

	// ---------------- assertions
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		slope_out.valid && !slope_out.ready |-> !diff_in.ready)
		else $error("input accepted while output stalled");

	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		slope_out.valid && slope_out.invalid_mode |-> slope_out.limited_value == '0)
		else $error("invalid mode with nonzero slope");

	a_quotient_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lv && !ls_l.zero_res && !ls_l.use_direct |-> lq <= 49'h1_0000_0000_0000)
		else $error("final quotient out of range");

endmodule

`default_nettype wire

// File: sv/ssl_frac_div.sv
// Pipelined unit fraction divider: one quotient bit per stage.
`default_nettype none

module ssl_frac_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         adv,
	input  wire logic                         in_valid,
	input  wire logic [ssl_pkg::RAT_W-1:0]    in_num,
	input  wire logic [ssl_pkg::RAT_W-1:0]    in_den,
	input  wire ssl_pkg::fside_t              in_side,
	output logic                              out_valid,
	output logic [ssl_pkg::FRAC_BITS-1:0]     out_q,
	output ssl_pkg::fside_t                   out_side
);
	localparam int STEPS = ssl_pkg::FRAC_BITS;
	localparam int W     = ssl_pkg::RAT_W;

	logic                 v_s    [0:STEPS];
	logic [W-1:0]         rem_s  [0:STEPS];
	logic [W-1:0]         den_s  [0:STEPS];
	logic [STEPS-1:0]     q_s    [0:STEPS];
	ssl_pkg::fside_t      side_s [0:STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0]  <= in_num;
			den_s[0]  <= in_den;
			q_s[0]    <= '0;
			side_s[0] <= in_side;
		end
	end

	for (genvar k = 1; k <= STEPS; k++) begin : g_step
		logic [W:0] sh;
		logic       ge;

		assign sh = {rem_s[k-1], 1'b0};
		assign ge = sh >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= ge ? W'(sh - {1'b0, den_s[k-1]}) : sh[W-1:0];
				den_s[k]  <= den_s[k-1];
				q_s[k]    <= {q_s[k-1][STEPS-2:0], ge};
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign out_q     = q_s[STEPS];
	assign out_side  = side_s[STEPS];

endmodule

`default_nettype wire

// File: sv/ssl_long_div.sv
// Pipelined restoring divider for the final quotient, one bit per stage.
`default_nettype none

module ssl_long_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         adv,
	input  wire logic                         in_valid,
	input  wire logic [ssl_pkg::NUM_W-1:0]    in_num,
	input  wire logic [ssl_pkg::DEN_W-1:0]    in_den,
	input  wire ssl_pkg::lside_t              in_side,
	output logic                              out_valid,
	output logic [ssl_pkg::QUOT_BITS-1:0]     out_q,
	output ssl_pkg::lside_t                   out_side
);
	localparam int QB = ssl_pkg::QUOT_BITS;
	localparam int DW = ssl_pkg::DEN_W;
	localparam int NW = ssl_pkg::NUM_W;

	logic              v_s    [0:QB];
	logic [DW-1:0]     rem_s  [0:QB];
	logic [QB-1:0]     lo_s   [0:QB];
	logic [DW-1:0]     den_s  [0:QB];
	logic [QB-1:0]     q_s    [0:QB];
	ssl_pkg::lside_t   side_s [0:QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_valid;
		end
	end

	// upper dividend bits are below the divisor, so the quotient fits QB bits
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0]  <= DW'(in_num[NW-1:QB]);
			lo_s[0]   <= in_num[QB-1:0];
			den_s[0]  <= in_den;
			q_s[0]    <= '0;
			side_s[0] <= in_side;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [DW:0] sh;
		logic        ge;

		assign sh = {rem_s[k-1], lo_s[k-1][QB-1]};
		assign ge = sh >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= ge ? DW'(sh - {1'b0, den_s[k-1]}) : sh[DW-1:0];
				lo_s[k]   <= {lo_s[k-1][QB-2:0], 1'b0};
				den_s[k]  <= den_s[k-1];
				q_s[k]    <= {q_s[k-1][QB-2:0], ge};
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[QB];
	assign out_q     = q_s[QB];
	assign out_side  = side_s[QB];

endmodule

`default_nettype wire
